[design/smpq_pkg.sv]
// Package for the stable min-priority queue.
// Holds the request/result word types, status and request codes, and the cell command.
// No dependencies.
`default_nettype none

package smpq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned TAG_BITS_DEF    = 16;
    localparam int unsigned PRIO_BITS_DEF   = 8;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] task_tag;
        logic [7:0]  priority_req;
    } req_word_t;

    typedef struct packed {
        status_t     status;
        logic        head_valid;
        logic [7:0]  head_priority;
        logic [15:0] head_tag;
        logic [4:0]  entry_count;
    } rsp_word_t;

    // Broadcast to every cell; at most one is set.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_cmd_t;

endpackage

`default_nettype wire

[design/smpq_cell.sv]
// One storage cell of the queue chain: holds one priority and tag.
// Depends on smpq_pkg (cell_cmd_t).
`default_nettype none

module smpq_cell #(
    parameter int unsigned TAG_BITS  = smpq_pkg::TAG_BITS_DEF,
    parameter int unsigned PRIO_BITS = smpq_pkg::PRIO_BITS_DEF
) (
    input  wire                    aclk,
    input  smpq_pkg::cell_cmd_t    cmd,
    input  wire                    valid,       // cell index below fill count
    input  wire  [PRIO_BITS-1:0]   new_prio,
    input  wire  [TAG_BITS-1:0]    new_tag,
    input  wire                    left_keep,   // tied high for the head cell
    input  wire  [PRIO_BITS-1:0]   left_prio,
    input  wire  [TAG_BITS-1:0]    left_tag,
    input  wire  [PRIO_BITS-1:0]   right_prio,
    input  wire  [TAG_BITS-1:0]    right_tag,
    output logic                   keep,
    output logic [PRIO_BITS-1:0]   prio,
    output logic [TAG_BITS-1:0]    tag
);

    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;

    // Entries with priority <= new one stay ahead of it (stable order).
    assign keep = valid && (prio_reg <= new_prio);
    assign prio = prio_reg;
    assign tag  = tag_reg;

    always_comb begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        if (cmd.push && !keep) begin
            if (left_keep) begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end else begin
                prio_next = left_prio;
                tag_next  = left_tag;
            end
        end else if (cmd.pop) begin
            prio_next = right_prio;
            tag_next  = right_tag;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

endmodule

`default_nettype wire

[design/stable_min_priority_queue_unit.sv]
// Stable min-priority queue: one result word per request word.
// Result valid in the cycle after request accept; one word per cycle while the receiver
// keeps m_ready high, set by the cell chain, which inserts or shifts all entries at once.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
// Depends on smpq_pkg and smpq_cell.
`default_nettype none

module stable_min_priority_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned TAG_BITS    = smpq_pkg::TAG_BITS_DEF,
    parameter int unsigned PRIO_BITS   = smpq_pkg::PRIO_BITS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  smpq_pkg::req_word_t  s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output smpq_pkg::rsp_word_t  m_data
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  m_valid_reg;
    smpq_pkg::status_t     status_reg, status_next;
    smpq_pkg::cell_cmd_t   cmd;
    logic                  accept, full, empty;
    logic [PRIO_BITS-1:0]  new_prio;
    logic [TAG_BITS-1:0]   new_tag;

    logic                  keep  [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0]  prio_q[QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   tag_q [QUEUE_DEPTH];

    // No word is taken while reset is held.
    assign s_ready  = aresetn && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign new_prio = PRIO_BITS'(s_data.priority_req);
    assign new_tag  = TAG_BITS'(s_data.task_tag);

    always_comb begin
        cmd         = '0;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        if (accept) begin
            status_next = smpq_pkg::ST_OK;
            if (s_data.req_type == smpq_pkg::REQ_PUSH) begin
                if (full) begin
                    status_next = smpq_pkg::ST_PUSH_FULL;
                end else begin
                    cmd.push = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end else begin
                if (empty) begin
                    status_next = smpq_pkg::ST_POP_EMPTY;
                end else begin
                    cmd.pop  = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                 l_keep;
            logic [PRIO_BITS-1:0] l_prio, r_prio;
            logic [TAG_BITS-1:0]  l_tag, r_tag;

            if (gi == 0) begin : g_head
                assign l_keep = 1'b1;
                assign l_prio = '0;
                assign l_tag  = '0;
            end else begin : g_mid
                assign l_keep = keep[gi-1];
                assign l_prio = prio_q[gi-1];
                assign l_tag  = tag_q[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign r_prio = '0;
                assign r_tag  = '0;
            end else begin : g_body
                assign r_prio = prio_q[gi+1];
                assign r_tag  = tag_q[gi+1];
            end

            smpq_cell #(
                .TAG_BITS  (TAG_BITS),
                .PRIO_BITS (PRIO_BITS)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .valid      (cnt_reg > CNT_W'(gi)),
                .new_prio   (new_prio),
                .new_tag    (new_tag),
                .left_keep  (l_keep),
                .left_prio  (l_prio),
                .left_tag   (l_tag),
                .right_prio (r_prio),
                .right_tag  (r_tag),
                .keep       (keep[gi]),
                .prio       (prio_q[gi]),
                .tag        (tag_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= smpq_pkg::ST_OK;
        end else begin
            cnt_reg     <= cnt_next;
            status_reg  <= status_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result word reads the queue state left by the last request; it only
    // changes on accept, which cannot happen while a word is stalled.
    assign m_valid               = m_valid_reg;
    assign m_data.status         = status_reg;
    assign m_data.head_valid     = !empty;
    assign m_data.head_priority  = empty ? '0 : 8'(prio_q[0]);
    assign m_data.head_tag       = empty ? '0 : 16'(tag_q[0]);
    assign m_data.entry_count    = 5'(cnt_reg);

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("push did not grow queue");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("pop did not shrink queue");

    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && status_reg == smpq_pkg::ST_PUSH_FULL |-> full)
        else $error("push refused while not full");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && status_reg == smpq_pkg::ST_POP_EMPTY |-> empty)
        else $error("pop flagged empty while entries held");

endmodule

`default_nettype wire

[sim/tb_stable_min_priority_queue_unit.sv]
// Self-checking testbench for stable_min_priority_queue_unit: push/pop request words in,
// status/head/count result words out, checked against a sorted-array queue kept in the bench.
// Depends on smpq_pkg and the design files.
module tb_stable_min_priority_queue_unit;
    import smpq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    req_word_t s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rsp_word_t m_data;

    // queue contents as the bench sees them, head at index 0
    logic [7:0]  sorted_prio [DEPTH];
    logic [15:0] sorted_tag  [DEPTH];
    int          held_count = 0;

    rsp_word_t pending_rsp [$];
    int        error_count = 0;
    int        cycle_count = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int hold_token     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    stable_min_priority_queue_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL stable_min_priority_queue_unit");
            $finish;
        end
    end

    // Apply one request to the bench copy of the queue and return the result word it gives.
    function automatic rsp_word_t apply_request(req_word_t req);
        rsp_word_t rsp;
        int        slot;
        int        k;
        rsp = '0;
        rsp.status = ST_OK;
        if (req.req_type == REQ_PUSH) begin
            if (held_count >= DEPTH) begin
                rsp.status = ST_PUSH_FULL;
            end else begin
                slot = 0;
                // equal priorities go behind existing ones
                while (slot < held_count && sorted_prio[slot] <= req.priority_req)
                    slot++;
                for (k = held_count; k > slot; k--) begin
                    sorted_prio[k] = sorted_prio[k - 1];
                    sorted_tag[k]  = sorted_tag[k - 1];
                end
                sorted_prio[slot] = req.priority_req;
                sorted_tag[slot]  = req.task_tag;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                rsp.status = ST_POP_EMPTY;
            end else begin
                for (k = 0; k + 1 < held_count; k++) begin
                    sorted_prio[k] = sorted_prio[k + 1];
                    sorted_tag[k]  = sorted_tag[k + 1];
                end
                held_count--;
            end
        end
        rsp.head_valid    = (held_count != 0);
        rsp.head_priority = (held_count != 0) ? sorted_prio[0] : 8'd0;
        rsp.head_tag      = (held_count != 0) ? sorted_tag[0] : 16'd0;
        rsp.entry_count   = 5'(held_count);
        return rsp;
    endfunction

    function automatic req_word_t build_request(req_type_t kind, logic [15:0] tag,
                                                logic [7:0] prio);
        req_word_t req;
        req.req_type     = kind;
        req.task_tag     = tag;
        req.priority_req = prio;
        return req;
    endfunction

    // Priorities lean toward a narrow band so ties are common.
    function automatic req_word_t random_request(int push_pct);
        req_type_t  kind;
        logic [7:0] prio;
        int         pick;
        kind = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
        pick = $urandom_range(99);
        if (pick < 45)
            prio = 8'($urandom_range(7));
        else if (pick < 55)
            prio = $urandom_range(1) ? 8'hFF : 8'h00;
        else
            prio = 8'($urandom_range(255));
        return build_request(kind, 16'($urandom_range(16'hFFFF)), prio);
    endfunction

    // Offer one word, hold it until accepted, then maybe go idle for a while.
    task automatic send_request(req_word_t req);
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_rsp.push_back(apply_request(req));
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge aclk);
    endtask

    // Result checker and receiver throttle.
    always @(posedge aclk) begin
        rsp_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result word: %h", m_data);
                error_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    error_count++;
                end
                if (m_data.head_valid !== want.head_valid) begin
                    $error("head_valid: expected %0d, got %0d",
                           want.head_valid, m_data.head_valid);
                    error_count++;
                end
                if (m_data.head_priority !== want.head_priority) begin
                    $error("head_priority: expected %0d, got %0d",
                           want.head_priority, m_data.head_priority);
                    error_count++;
                end
                if (m_data.head_tag !== want.head_tag) begin
                    $error("head_tag: expected %h, got %h", want.head_tag, m_data.head_tag);
                    error_count++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_data.entry_count);
                    error_count++;
                end
            end
        end
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= hold_len;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Pop on empty, fill to the brim with extremes and ties, push when full, pops with junk fields.
    task automatic test_directed_cases();
        logic [23:0] fill_list [DEPTH] = '{
            {16'hFFFF, 8'hFF}, {16'h0000, 8'h00}, {16'h0001, 8'h00}, {16'h1234, 8'hFF},
            {16'hAAAA, 8'h80}, {16'h5555, 8'h7F}, {16'h0002, 8'h00}, {16'h8000, 8'h01},
            {16'h0001, 8'hFE}, {16'hBEEF, 8'h80}, {16'hCAFE, 8'h40}, {16'hF00D, 8'h40},
            {16'h0BAD, 8'hC0}, {16'h7FFF, 8'h80}, {16'hDEAD, 8'h10}, {16'h0003, 8'h00}
        };
        int i;
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        send_request(build_request(REQ_POP, 16'hFFFF, 8'hFF));
        for (i = 0; i < DEPTH; i++)
            send_request(build_request(REQ_PUSH, fill_list[i][23:8], fill_list[i][7:0]));
        send_request(build_request(REQ_PUSH, 16'hABCD, 8'h00));
        send_request(build_request(REQ_POP, 16'hFFFF, 8'hFF));
        send_request(build_request(REQ_POP, 16'h0000, 8'h00));
        send_request(build_request(REQ_POP, 16'h5A5A, 8'hA5));
        send_request(build_request(REQ_POP, 16'hFFFF, 8'h00));
        pause_until_drained();
    endtask

    // Bursts with a shifting push/pop mix, so the queue swings between empty and full.
    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        int mixes [5] = '{85, 15, 50, 65, 35};
        int push_pct;
        int i;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        push_pct = 50;
        for (i = 0; i < count; i++) begin
            if (i % 30 == 0)
                push_pct = mixes[$urandom_range(4)];
            send_request(random_request(push_pct));
        end
        pause_until_drained();
    endtask

    // Receiver goes deaf for a long stretch while words keep coming; input must back up.
    task automatic test_output_backpressure();
        int i;
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_len   <= 60;
        hold_token <= hold_token + 1;
        for (i = 0; i < 40; i++)
            send_request(random_request(60));
        pause_until_drained();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_traffic(390, 0, 0);
        test_random_traffic(390, 46, 0);
        test_output_backpressure();
        test_random_traffic(390, 0, 46);
        test_random_traffic(390, 37, 37);
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("PASS stable_min_priority_queue_unit");
        else
            $display("FAIL stable_min_priority_queue_unit");
        $finish;
    end

endmodule
